// File: rtl/isp_pkg.sv
package isp_pkg;

    // address and region geometry
    localparam int ADDR_W            = 48;
    localparam int PREC_BITS         = 2;
    localparam int SUCC_BITS         = 8;
    localparam int RECENT_DEPTH      = 2;
    localparam int HISTORY_DEPTH     = 16;
    localparam int LOOKUP_DEPTH      = 64;
    localparam int STREAM_ENTRIES    = 8;

    // derived widths
    localparam int NPOS      = PREC_BITS + SUCC_BITS;
    localparam int POS_W     = $clog2(NPOS);
    localparam int HIST_W    = $clog2(HISTORY_DEPTH);
    localparam int IDX_W     = $clog2(LOOKUP_DEPTH);
    localparam int AGE_W     = IDX_W;
    localparam int STR_W     = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
    localparam int STR_CNT_W = $clog2(STREAM_ENTRIES + 1);
    localparam int CMP_W     = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int CMP_CNT_W = $clog2(RECENT_DEPTH + 1);
    localparam int LG_W      = 4;

    // configuration register map
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_LOG_BLOCK_SIZE = '0;
    localparam logic [LG_W-1:0]    LG_RESET           = 4'd6;

    // item kinds
    localparam logic KIND_RETIRE = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] prefetch_address;
        logic              has_address;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]    trig;
        logic [PREC_BITS-1:0] prec;
        logic [SUCC_BITS-1:0] succ;
    } t_region;

    typedef struct packed {
        logic            start;
        logic [LG_W-1:0] lg;
        t_region         region;
    } t_pred_req;

endpackage

// File: rtl/isp_pred_gen.sv
module isp_pred_gen
    import isp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pred_req i_req,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    output logic      o_busy
);

    logic              r_busy;
    logic              r_empty;
    logic [NPOS-1:0]   r_vec;
    logic [ADDR_W-1:0] r_tb;
    logic [LG_W-1:0]   r_lg;
    logic [POS_W-1:0]  r_pos;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              load_ok;
    logic              later;
    logic              cur_set;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] blk_addr;
    logic [NPOS-1:0]   start_vec;

    // bit vector in emission order: preceding blocks nearest-last, then following blocks
    always_comb begin
        for (int p = 0; p < PREC_BITS; p++) begin
            start_vec[p] = i_req.region.prec[PREC_BITS-1-p];
        end
        for (int s = 0; s < SUCC_BITS; s++) begin
            start_vec[PREC_BITS+s] = i_req.region.succ[s];
        end
    end

    // current position address and whether more set bits follow
    always_comb begin
        load_ok = !r_out_valid || !i_out_stall;
        cur_set = r_vec[r_pos];
        later   = 1'b0;
        for (int p = 0; p < NPOS; p++) begin
            if (POS_W'(p) > r_pos && r_vec[p]) begin
                later = 1'b1;
            end
        end
        if (r_pos < POS_W'(PREC_BITS)) begin
            blk = r_tb - (ADDR_W'(PREC_BITS) - ADDR_W'(r_pos));
        end else begin
            blk = r_tb + (ADDR_W'(r_pos) - ADDR_W'(PREC_BITS) + ADDR_W'(1));
        end
        blk_addr = blk << r_lg;
    end

    // one position per cycle into the output register, while the output register is not held by a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_empty <= (start_vec == '0);
                r_vec   <= start_vec;
                r_tb    <= i_req.region.trig >> i_req.lg;
                r_lg    <= i_req.lg;
                r_pos   <= '0;
                if (r_out_valid && !i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end else if (r_busy && load_ok) begin
                if (r_empty) begin
                    r_out.prefetch_address <= '0;
                    r_out.has_address      <= 1'b0;
                    r_out.last             <= 1'b1;
                    r_out_valid            <= 1'b1;
                    r_busy                 <= 1'b0;
                end else if (cur_set) begin
                    r_out.prefetch_address <= blk_addr;
                    r_out.has_address      <= 1'b1;
                    r_out.last             <= !later;
                    r_out_valid            <= 1'b1;
                    if (!later) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                    if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_busy      = r_busy;

endmodule

// File: rtl/instruction_stream_prefetcher.sv
// Retired item: returns to idle from S_RET when it extends the open region or hits the compactor;
// when it closes a region it runs an index search sweep and then an index update sweep.
// Fetch item: each active stream is read and checked in turn; a stream hit goes to the prediction,
// an index miss follows one index sweep, an index hit two sweeps, then up to NPOS positions to emit.
// One item in flight at a time; index memory sweeps set the throughput.
// Reset clears control state and valid bits at once; no clearing pass.
module instruction_stream_prefetcher
    import isp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef struct packed {
        logic                 member;
        logic                 has;
        logic [PREC_BITS-1:0] prec_bit;
        logic [SUCC_BITS-1:0] succ_bit;
    } t_match;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [HIST_W-1:0] slot;
        logic [AGE_W-1:0]  age;
    } t_lk_entry;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RET      = 4'd1;
    localparam logic [3:0] S_STR_RD   = 4'd2;
    localparam logic [3:0] S_STR_CHK  = 4'd3;
    localparam logic [3:0] S_IDX_SRCH = 4'd4;
    localparam logic [3:0] S_IDX_UPD  = 4'd5;
    localparam logic [3:0] S_PRED     = 4'd6;

    localparam logic [IDX_W:0] J_END = (IDX_W+1)'(LOOKUP_DEPTH);

    // membership of an address in a region, with the bit it would set
    function automatic t_match f_match(input t_region r, input logic [ADDR_W-1:0] a,
                                       input logic [LG_W-1:0] lg);
        logic [ADDR_W-1:0] ab;
        logic [ADDR_W-1:0] tb;
        logic [ADDR_W-1:0] d;
        t_match            m;
        ab = a >> lg;
        tb = r.trig >> lg;
        d  = (ab > tb) ? ab - tb : tb - ab;
        m  = '0;
        for (int i = 0; i < PREC_BITS; i++) begin
            m.prec_bit[i] = (d == ADDR_W'(i + 1));
        end
        for (int i = 0; i < SUCC_BITS; i++) begin
            m.succ_bit[i] = (d == ADDR_W'(i + 1));
        end
        if (d == '0) begin
            m.member   = 1'b1;
            m.has      = 1'b1;
            m.prec_bit = '0;
            m.succ_bit = '0;
        end else if (a > r.trig) begin
            m.prec_bit = '0;
            m.member   = |m.succ_bit;
            m.has      = |(m.succ_bit & r.succ);
        end else begin
            m.succ_bit = '0;
            m.member   = |m.prec_bit;
            m.has      = |(m.prec_bit & r.prec);
        end
        return m;
    endfunction

    function automatic logic [STR_W-1:0] f_str_add(input logic [STR_W-1:0] a,
                                                  input logic [STR_CNT_W-1:0] b);
        logic [STR_CNT_W:0] s;
        s = (STR_CNT_W+1)'(a) + (STR_CNT_W+1)'(b);
        if (s >= (STR_CNT_W+1)'(STREAM_ENTRIES)) begin
            s = s - (STR_CNT_W+1)'(STREAM_ENTRIES);
        end
        return s[STR_W-1:0];
    endfunction

    // control and item registers
    logic [3:0]           r_state;
    t_in_item             r_item;
    logic [LG_W-1:0]      r_lg;
    logic [ADDR_W-1:0]    r_key;
    logic                 r_zero;

    // open region and compactor
    t_region              r_cur;
    logic                 r_started;
    t_region              r_recent [RECENT_DEPTH];
    logic [CMP_CNT_W-1:0] r_rec_cnt;

    // history ring
    t_region              r_hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hvalid;
    logic [HIST_W-1:0]    r_tail;
    t_region              r_hist_q;
    logic                 r_hist_rv;

    // index
    t_lk_entry            r_lk_mem [LOOKUP_DEPTH];
    logic [LOOKUP_DEPTH-1:0] r_lk_valid;
    t_lk_entry            r_lk_q;
    logic [IDX_W:0]       r_j;
    logic                 r_chk_v;
    logic [IDX_W-1:0]     r_chk_j;
    logic                 r_found;
    logic [IDX_W-1:0]     r_e;
    logic [AGE_W-1:0]     r_old_age;
    logic [HIST_W-1:0]    r_e_slot;
    logic                 r_free_f;
    logic [IDX_W-1:0]     r_free;
    logic [IDX_W-1:0]     r_lru;
    logic [IDX_W:0]       r_thr;

    // stream buffer
    logic [HIST_W-1:0]    r_str_slot [STREAM_ENTRIES];
    logic [STR_CNT_W-1:0] r_str_cnt;
    logic [STR_W-1:0]     r_str_head;
    logic [STR_CNT_W-1:0] r_k;
    logic [STR_W-1:0]     r_s;

    // combinational helpers
    logic                 in_xfer;
    logic                 cfg_wr;
    logic                 pg_busy;
    t_pred_req            pred_req;
    t_match               cm_cur;
    t_match               cm_rec [RECENT_DEPTH];
    logic                 cm_found;
    logic [CMP_W-1:0]     cm_k;
    t_region              cm_sel;
    t_region              cm_recent [RECENT_DEPTH];
    t_region              cm_tmp [RECENT_DEPTH];
    logic [CMP_CNT_W-1:0] cm_cnt;
    logic [CMP_CNT_W-1:0] cm_c;
    logic [HIST_W-1:0]    tail_nx;
    logic                 hist_we;
    logic [HIST_W-1:0]    hist_ra;
    t_region              hist_rd;
    t_match               sm;
    logic [STR_W-1:0]     str_rd_idx;
    logic [HIST_W-1:0]    slot_nx;
    logic                 lk_we;
    t_lk_entry            lk_wd;
    logic                 sweep_end;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_LOG_BLOCK_SIZE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[PADDR_W-1:2] == REG_LOG_BLOCK_SIZE) ?
                     {{(32-LG_W){1'b0}}, r_lg} : '0;
    assign o_in_stall = !(r_state == S_IDLE && !pg_busy);

    // compactor search and reordering for a retired address outside the open region
    always_comb begin
        cm_cur   = f_match(r_cur, r_item.address, r_lg);
        cm_found = 1'b0;
        cm_k     = '0;
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            cm_rec[k] = f_match(r_recent[k], r_item.address, r_lg);
            if (!cm_found && CMP_CNT_W'(k) < r_rec_cnt && cm_rec[k].member) begin
                cm_found = 1'b1;
                cm_k     = CMP_W'(k);
            end
        end
        cm_sel = r_cur;
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            cm_tmp[k] = r_recent[k];
            if (cm_found && CMP_W'(k) == cm_k) begin
                cm_sel = r_recent[k];
            end
        end
        cm_c = r_rec_cnt;
        if (cm_found) begin
            for (int k = 0; k < RECENT_DEPTH - 1; k++) begin
                if (CMP_W'(k) >= cm_k) begin
                    cm_tmp[k] = r_recent[k+1];
                end
            end
            cm_c = cm_c - CMP_CNT_W'(1);
        end
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            cm_recent[k] = cm_tmp[k];
        end
        if (cm_c >= CMP_CNT_W'(RECENT_DEPTH)) begin
            for (int k = 0; k < RECENT_DEPTH - 1; k++) begin
                cm_recent[k] = cm_tmp[k+1];
            end
            cm_c = CMP_CNT_W'(RECENT_DEPTH - 1);
        end
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            if (CMP_CNT_W'(k) == cm_c) begin
                cm_recent[k] = cm_sel;
            end
        end
        cm_cnt = cm_c + CMP_CNT_W'(1);
    end

    // history ring access
    assign tail_nx = (r_tail == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : r_tail + HIST_W'(1);
    assign hist_we = (r_state == S_RET) && r_started && !cm_cur.member && !cm_found;
    assign hist_rd = (r_hist_rv && !r_zero) ? r_hist_q : '0;

    assign str_rd_idx = f_str_add(r_str_head, r_k);
    assign slot_nx    = (r_str_slot[r_s] == HIST_W'(HISTORY_DEPTH - 1)) ?
                        '0 : r_str_slot[r_s] + HIST_W'(1);
    assign sm         = f_match(hist_rd, r_item.address, r_lg);

    always_comb begin
        hist_ra = r_e_slot;
        if (r_state == S_STR_RD) begin
            hist_ra = r_str_slot[str_rd_idx];
        end else if (r_state == S_STR_CHK) begin
            hist_ra = slot_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[tail_nx] <= r_cur;
        end
        r_hist_q  <= r_hist_mem[hist_ra];
        r_hist_rv <= r_hvalid[hist_ra];
    end

    // index read-modify-write: aging and target entry rewrite
    assign sweep_end = (r_j == J_END) && !r_chk_v;

    always_comb begin
        lk_we = 1'b0;
        lk_wd = r_lk_q;
        if (r_state == S_IDX_UPD && r_chk_v) begin
            if (r_chk_j == r_e) begin
                lk_we     = 1'b1;
                lk_wd.tag = r_key;
                lk_wd.age = '0;
                if (r_item.kind == KIND_RETIRE) begin
                    lk_wd.slot = r_tail;
                end
            end else if (r_lk_valid[r_chk_j] && {1'b0, r_lk_q.age} < r_thr) begin
                lk_we     = 1'b1;
                lk_wd.age = r_lk_q.age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_lk_mem[r_chk_j] <= lk_wd;
        end
        r_lk_q <= r_lk_mem[r_j[IDX_W-1:0]];
    end

    // prediction request
    always_comb begin
        pred_req.start  = (r_state == S_PRED);
        pred_req.lg     = r_lg;
        pred_req.region = hist_rd;
    end

    isp_pred_gen u_pred_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (pred_req),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_busy      (pg_busy)
    );

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lg       <= LG_RESET;
            r_zero     <= 1'b0;
            r_started  <= 1'b0;
            r_cur      <= '0;
            r_rec_cnt  <= '0;
            r_hvalid   <= '0;
            r_tail     <= HIST_W'(HISTORY_DEPTH - 1);
            r_lk_valid <= '0;
            r_str_cnt  <= '0;
            r_str_head <= '0;
            r_chk_v    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_lg <= pwdata[LG_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_item <= i_in_data;
                        r_key  <= i_in_data.address;
                        r_k    <= '0;
                        if (i_in_data.kind == KIND_RETIRE) begin
                            r_state <= S_RET;
                        end else if (r_str_cnt == '0) begin
                            r_j      <= '0;
                            r_chk_v  <= 1'b0;
                            r_found  <= 1'b0;
                            r_free_f <= 1'b0;
                            r_state  <= S_IDX_SRCH;
                        end else begin
                            r_state <= S_STR_RD;
                        end
                    end
                end
                S_RET: begin
                    if (!r_started) begin
                        r_state     <= S_IDLE;
                        r_started   <= 1'b1;
                        r_cur.trig  <= r_item.address;
                        r_cur.prec  <= '0;
                        r_cur.succ  <= '0;
                        r_recent[0] <= '{trig: r_item.address, prec: '0, succ: '0};
                        r_rec_cnt   <= CMP_CNT_W'(1);
                    end else if (cm_cur.member) begin
                        r_state    <= S_IDLE;
                        r_cur.prec <= r_cur.prec | cm_cur.prec_bit;
                        r_cur.succ <= r_cur.succ | cm_cur.succ_bit;
                    end else begin
                        r_recent  <= cm_recent;
                        r_rec_cnt <= cm_cnt;
                        if (cm_found) begin
                            r_cur   <= cm_sel;
                            r_state <= S_IDLE;
                        end else begin
                            r_tail            <= tail_nx;
                            r_hvalid[tail_nx] <= 1'b1;
                            r_key             <= r_cur.trig;
                            r_cur.trig        <= r_item.address;
                            r_cur.prec        <= '0;
                            r_cur.succ        <= '0;
                            r_j               <= '0;
                            r_chk_v           <= 1'b0;
                            r_found           <= 1'b0;
                            r_free_f          <= 1'b0;
                            r_state           <= S_IDX_SRCH;
                        end
                    end
                end
                S_STR_RD: begin
                    r_s     <= str_rd_idx;
                    r_state <= S_STR_CHK;
                end
                S_STR_CHK: begin
                    if (sm.has) begin
                        r_str_slot[r_s] <= slot_nx;
                        r_zero          <= 1'b0;
                        r_state         <= S_PRED;
                    end else if (r_k + STR_CNT_W'(1) == r_str_cnt) begin
                        r_j      <= '0;
                        r_chk_v  <= 1'b0;
                        r_found  <= 1'b0;
                        r_free_f <= 1'b0;
                        r_state  <= S_IDX_SRCH;
                    end else begin
                        r_k     <= r_k + STR_CNT_W'(1);
                        r_state <= S_STR_RD;
                    end
                end
                S_IDX_SRCH: begin
                    r_chk_v <= (r_j < J_END);
                    r_chk_j <= r_j[IDX_W-1:0];
                    if (r_j < J_END) begin
                        r_j <= r_j + (IDX_W+1)'(1);
                    end
                    if (r_chk_v) begin
                        if (r_lk_valid[r_chk_j] && r_lk_q.tag == r_key && !r_found) begin
                            r_found   <= 1'b1;
                            r_e       <= r_chk_j;
                            r_old_age <= r_lk_q.age;
                            r_e_slot  <= r_lk_q.slot;
                        end
                        if (!r_lk_valid[r_chk_j] && !r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_chk_j;
                        end
                        if (r_lk_valid[r_chk_j] && r_lk_q.age == AGE_W'(LOOKUP_DEPTH - 1)) begin
                            r_lru <= r_chk_j;
                        end
                    end
                    if (sweep_end) begin
                        if (r_item.kind == KIND_FETCH && !r_found) begin
                            // no stream and no index hit: empty prediction
                            r_zero  <= 1'b1;
                            r_state <= S_PRED;
                        end else begin
                            priority if (r_found) begin
                                r_thr <= {1'b0, r_old_age};
                            end else if (r_free_f) begin
                                r_e   <= r_free;
                                r_thr <= J_END;
                            end else begin
                                r_e   <= r_lru;
                                r_thr <= J_END - (IDX_W+1)'(1);
                            end
                            r_j     <= '0;
                            r_state <= S_IDX_UPD;
                        end
                    end
                end
                S_IDX_UPD: begin
                    r_chk_v <= (r_j < J_END);
                    r_chk_j <= r_j[IDX_W-1:0];
                    if (r_j < J_END) begin
                        r_j <= r_j + (IDX_W+1)'(1);
                    end
                    if (sweep_end) begin
                        r_lk_valid[r_e] <= 1'b1;
                        if (r_item.kind == KIND_RETIRE) begin
                            r_state <= S_IDLE;
                        end else begin
                            // open a stream, replacing the oldest when full
                            if (r_str_cnt >= STR_CNT_W'(STREAM_ENTRIES)) begin
                                r_str_slot[r_str_head] <= r_e_slot;
                                r_str_head <= f_str_add(r_str_head, STR_CNT_W'(1));
                            end else begin
                                r_str_slot[f_str_add(r_str_head, r_str_cnt)] <= r_e_slot;
                                r_str_cnt <= r_str_cnt + STR_CNT_W'(1);
                            end
                            r_zero  <= 1'b0;
                            r_state <= S_PRED;
                        end
                    end
                end
                S_PRED: begin
                    r_zero  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // stream count stays within the buffer
    a_str_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_str_cnt <= STR_CNT_W'(STREAM_ENTRIES))
        else $error("stream count exceeds buffer size");

    // a retired item gives no result transfer
    a_retire_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.kind == KIND_RETIRE && !o_out_valid) |=> !o_out_valid)
        else $error("result produced for retired item");

    // prediction starts only when the generator is free
    a_pred_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED) |-> !pg_busy)
        else $error("prediction started while generator busy");

    // compactor stays empty until the first region opens
    a_cmp_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_rec_cnt == '0))
        else $error("compactor filled before first region");

endmodule

// File: tb/tb_instruction_stream_prefetcher.sv
module tb_instruction_stream_prefetcher
    import isp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 310;
    localparam int SETTLE_CYCLES = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    instruction_stream_prefetcher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [LG_W-1:0]   blk_shift;
    t_region           open_rgn;
    bit                rgn_started;
    t_region           compactor[RECENT_DEPTH];
    int                compactor_n;
    t_region           history[HISTORY_DEPTH];
    int                history_tail;
    logic [ADDR_W-1:0] index_tag[LOOKUP_DEPTH];
    int                index_slot[LOOKUP_DEPTH];
    bit                index_vld[LOOKUP_DEPTH];
    int                index_age[LOOKUP_DEPTH];
    int                stream_slot[STREAM_ENTRIES];
    int                stream_n;
    int                stream_head;

    t_out_item         pending_prefetches[$];
    int                errors;
    int                items_sent;
    int                fetches_sent;
    int                prefetches_seen;
    int                hold_cycles;
    bit                calm;
    logic [ADDR_W-1:0] hot_pcs[6];
    logic [ADDR_W-1:0] cold_pcs[$];

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // block distance between an address and a region trigger
    function automatic logic [63:0] blk_gap(t_region r, logic [ADDR_W-1:0] a);
        logic [63:0] ab;
        logic [63:0] tb;
        ab = 64'(a) >> blk_shift;
        tb = 64'(r.trig) >> blk_shift;
        return (ab > tb) ? ab - tb : tb - ab;
    endfunction

    function automatic bit region_covers(t_region r, logic [ADDR_W-1:0] a);
        logic [63:0] d;
        d = blk_gap(r, a);
        if (d == 0) return 1'b1;
        if (a > r.trig) return d <= SUCC_BITS;
        return d <= PREC_BITS;
    endfunction

    function automatic t_region region_mark(t_region r, logic [ADDR_W-1:0] a);
        logic [63:0] d;
        t_region     m;
        d = blk_gap(r, a);
        m = r;
        if (d != 0) begin
            if (a > r.trig) begin
                if (d <= SUCC_BITS) m.succ[d-1] = 1'b1;
            end else if (d <= PREC_BITS) begin
                m.prec[d-1] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic bit region_holds(t_region r, logic [ADDR_W-1:0] a);
        logic [63:0] d;
        d = blk_gap(r, a);
        if (d == 0) return 1'b1;
        if (a > r.trig) return d <= SUCC_BITS && r.succ[d-1];
        return d <= PREC_BITS && r.prec[d-1];
    endfunction

    // append one expected result transfer
    function automatic void expect_result(t_out_item o);
        pending_prefetches.insert(pending_prefetches.size(), o);
    endfunction

    // expected prefetch addresses for one region
    function automatic void predict_prefetch(t_region r);
        int          n0;
        t_out_item   o;
        logic [63:0] tb;
        n0 = pending_prefetches.size();
        tb = 64'(r.trig) >> blk_shift;
        for (int i = PREC_BITS - 1; i >= 0; i--) begin
            if (r.prec[i]) begin
                o.prefetch_address = ADDR_W'((tb - 64'(i + 1)) << blk_shift);
                o.has_address = 1'b1;
                o.last = 1'b0;
                expect_result(o);
            end
        end
        for (int i = 0; i < SUCC_BITS; i++) begin
            if (r.succ[i]) begin
                o.prefetch_address = ADDR_W'((tb + 64'(i + 1)) << blk_shift);
                o.has_address = 1'b1;
                o.last = 1'b0;
                expect_result(o);
            end
        end
        if (pending_prefetches.size() == n0) begin
            o = '{prefetch_address: '0, has_address: 1'b0, last: 1'b1};
            expect_result(o);
        end
        pending_prefetches[pending_prefetches.size()-1].last = 1'b1;
    endfunction

    function automatic void index_touch(int e);
        int old;
        old = index_age[e];
        for (int j = 0; j < LOOKUP_DEPTH; j++)
            if (index_vld[j] && index_age[j] < old) index_age[j]++;
        index_age[e] = 0;
    endfunction

    function automatic int index_find(logic [ADDR_W-1:0] tag);
        for (int j = 0; j < LOOKUP_DEPTH; j++)
            if (index_vld[j] && index_tag[j] == tag) return j;
        return -1;
    endfunction

    function automatic int index_insert(logic [ADDR_W-1:0] tag);
        int v;
        v = -1;
        for (int j = 0; j < LOOKUP_DEPTH; j++) begin
            if (!index_vld[j]) begin
                v = j;
                break;
            end
        end
        if (v >= 0) begin
            for (int j = 0; j < LOOKUP_DEPTH; j++)
                if (index_vld[j]) index_age[j]++;
            index_vld[v] = 1'b1;
            index_age[v] = 0;
        end else begin
            v = 0;
            for (int j = 1; j < LOOKUP_DEPTH; j++)
                if (index_age[j] > index_age[v]) v = j;
            index_touch(v);
        end
        index_tag[v] = tag;
        return v;
    endfunction

    // retired pc: grow, recall or close a region
    function automatic void track_retire(logic [ADDR_W-1:0] a);
        bit found;
        int e;
        if (!rgn_started) begin
            rgn_started = 1'b1;
            open_rgn = '{trig: a, prec: '0, succ: '0};
            compactor[0] = open_rgn;
            compactor_n = 1;
            return;
        end
        if (region_covers(open_rgn, a)) begin
            open_rgn = region_mark(open_rgn, a);
            return;
        end
        found = 1'b0;
        for (int k = 0; k < compactor_n; k++) begin
            if (region_covers(compactor[k], a)) begin
                open_rgn = compactor[k];
                for (int j = k; j < compactor_n - 1; j++) compactor[j] = compactor[j+1];
                compactor_n--;
                found = 1'b1;
                break;
            end
        end
        if (compactor_n >= RECENT_DEPTH) begin
            for (int j = 0; j < RECENT_DEPTH - 1; j++) compactor[j] = compactor[j+1];
            compactor_n = RECENT_DEPTH - 1;
        end
        compactor[compactor_n] = open_rgn;
        compactor_n++;
        if (found) return;
        history_tail = (history_tail + 1) % HISTORY_DEPTH;
        history[history_tail] = open_rgn;
        e = index_find(open_rgn.trig);
        if (e >= 0) index_touch(e);
        else e = index_insert(open_rgn.trig);
        index_slot[e] = history_tail;
        open_rgn = '{trig: a, prec: '0, succ: '0};
    endfunction

    // fetch access: stream hit, index hit or nothing
    function automatic void track_fetch(logic [ADDR_W-1:0] a);
        int s;
        int e;
        t_out_item none;
        for (int k = 0; k < stream_n; k++) begin
            s = (stream_head + k) % STREAM_ENTRIES;
            if (region_holds(history[stream_slot[s]], a)) begin
                stream_slot[s] = (stream_slot[s] + 1) % HISTORY_DEPTH;
                predict_prefetch(history[stream_slot[s]]);
                return;
            end
        end
        e = index_find(a);
        if (e < 0) begin
            none = '{prefetch_address: '0, has_address: 1'b0, last: 1'b1};
            expect_result(none);
            return;
        end
        index_touch(e);
        if (stream_n >= STREAM_ENTRIES) begin
            stream_slot[stream_head] = index_slot[e];
            stream_head = (stream_head + 1) % STREAM_ENTRIES;
        end else begin
            stream_slot[(stream_head + stream_n) % STREAM_ENTRIES] = index_slot[e];
            stream_n++;
        end
        predict_prefetch(history[index_slot[e]]);
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transfer, predicted when accepted
    task automatic send_item(logic k, logic [ADDR_W-1:0] a);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{kind: k, address: a};
        do @(posedge i_clk); while (o_in_stall);
        if (k == KIND_RETIRE) begin
            track_retire(a);
        end else begin
            track_fetch(a);
            fetches_sent++;
        end
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_prefetches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_size(logic [LG_W-1:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_LOG_BLOCK_SIZE, 2'b00};
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        blk_shift = v;
    endtask

    function automatic logic [ADDR_W-1:0] near_pc(logic [ADDR_W-1:0] base, int d);
        logic [63:0] b;
        b = (64'(base) >> blk_shift) + 64'(d);
        return ADDR_W'((b << blk_shift) | 64'($urandom & ((32'd1 << blk_shift) - 1)));
    endfunction

    task automatic refresh_hot_pcs();
        for (int i = 0; i < 6; i++) begin
            if (i < 3) hot_pcs[i] = ADDR_W'($urandom_range(1, 4095)) << 12;
            else hot_pcs[i] = ADDR_W'({$urandom, $urandom});
        end
    endtask

    // mostly region-building retires and fetches on known triggers, some noise
    task automatic send_structured();
        int r;
        int h;
        r = $urandom_range(0, 99);
        h = $urandom_range(0, 5);
        if (r < 40) send_item(KIND_RETIRE, near_pc(hot_pcs[h], $urandom_range(0, 12) - 3));
        else if (r < 55) send_item(KIND_RETIRE, hot_pcs[h]);
        else if (r < 78) send_item(KIND_FETCH, hot_pcs[h]);
        else if (r < 92) send_item(KIND_FETCH, near_pc(hot_pcs[h], $urandom_range(0, 12) - 3));
        else send_item(logic'($urandom_range(0, 1)), ADDR_W'({$urandom, $urandom}));
    endtask

    task automatic test_directed();
        logic [ADDR_W-1:0] top;
        top = '1;
        send_item(KIND_FETCH, 48'h0);
        send_item(KIND_RETIRE, 48'h1000);
        send_item(KIND_RETIRE, 48'h1040);
        send_item(KIND_RETIRE, 48'h1200);
        send_item(KIND_RETIRE, 48'h0fc0);
        send_item(KIND_RETIRE, 48'h0f80);
        send_item(KIND_RETIRE, 48'h1005);
        send_item(KIND_RETIRE, 48'h1300);
        send_item(KIND_RETIRE, top & ~48'h3f);
        send_item(KIND_RETIRE, top);
        send_item(KIND_RETIRE, 48'h40);
        send_item(KIND_RETIRE, 48'h0);
        send_item(KIND_RETIRE, 48'h1080);
        send_item(KIND_RETIRE, 48'h5000);
        send_item(KIND_FETCH, 48'h1000);
        send_item(KIND_FETCH, 48'h1040);
        send_item(KIND_FETCH, 48'h1080);
        send_item(KIND_FETCH, top & ~48'h3f);
        send_item(KIND_FETCH, 48'h40);
        send_item(KIND_FETCH, top);
        send_item(KIND_FETCH, 48'h1300);
        send_item(KIND_FETCH, 48'h5000);
        wait_idle();
    endtask

    task automatic test_block_sizes();
        logic [LG_W-1:0] sizes[5];
        sizes = '{4'd2, 4'd12, 4'd0, 4'd15, LG_RESET};
        foreach (sizes[i]) begin
            write_block_size(sizes[i]);
            refresh_hot_pcs();
            repeat (28) send_structured();
            wait_idle();
        end
    endtask

    // fill the index past capacity and the stream buffer past its size
    task automatic test_index_fill();
        logic [ADDR_W-1:0] pc;
        for (int i = 0; i < 72; i++) begin
            pc = ADDR_W'({$urandom, $urandom});
            cold_pcs.insert(cold_pcs.size(), pc);
            send_item(KIND_RETIRE, pc);
        end
        send_item(KIND_RETIRE, 48'h7);
        for (int i = 0; i < 14; i++)
            send_item(KIND_FETCH, cold_pcs[$urandom_range(0, cold_pcs.size() - 1)]);
        for (int i = 60; i < 72; i++) send_item(KIND_FETCH, cold_pcs[i]);
        wait_idle();
    endtask

    // long receiver hold while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        refresh_hot_pcs();
        calm = 1'b1;
        repeat (8) send_structured();
        hold_cycles = 300;
        repeat (24) send_item(KIND_FETCH, hot_pcs[$urandom_range(0, 5)]);
        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_prefetches.size() != 0) @(posedge i_clk);
        repeat (8) send_structured();
        wait_idle();
    endtask

    task automatic test_random();
        refresh_hot_pcs();
        while (items_sent < ITEM_TARGET) begin
            if (items_sent % 50 == 0) refresh_hot_pcs();
            calm = ($urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 10)) send_structured();
        end
        calm = 1'b0;
        wait_idle();
    endtask

    // receiver stall pattern
    initial begin
        int g;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            g = pick_gap();
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (g > 0) begin
                i_out_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each output transfer with the oldest expected prefetch
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            prefetches_seen++;
            if (pending_prefetches.size() == 0) begin
                $error("unexpected output transfer, address %h", o_out_data.prefetch_address);
                errors++;
            end else begin
                want = pending_prefetches[0];
                pending_prefetches.delete(0);
                if (o_out_data.prefetch_address !== want.prefetch_address) begin
                    $error("prefetch_address expected %h actual %h",
                           want.prefetch_address, o_out_data.prefetch_address);
                    errors++;
                end
                if (o_out_data.has_address !== want.has_address) begin
                    $error("has_address expected %b actual %b",
                           want.has_address, o_out_data.has_address);
                    errors++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last expected %b actual %b", want.last, o_out_data.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        items_sent = 0;
        fetches_sent = 0;
        prefetches_seen = 0;
        hold_cycles = 0;
        calm = 1'b0;
        blk_shift = LG_RESET;
        open_rgn = '0;
        rgn_started = 1'b0;
        compactor_n = 0;
        foreach (history[i]) history[i] = '0;
        history_tail = HISTORY_DEPTH - 1;
        foreach (index_vld[i]) begin
            index_vld[i] = 1'b0;
            index_age[i] = 0;
        end
        stream_n = 0;
        stream_head = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_block_sizes();
        test_index_fill();
        test_backpressure();
        test_random();

        $display("covered %0d items (%0d fetches), %0d output transfers checked",
                 items_sent, fetches_sent, prefetches_seen);
        $display("block sizes 2^0..2^15, index overflow, stream reuse, long output hold");
        if (errors == 0 && pending_prefetches.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
